/* design/rsc_pkg.sv */
// rsc_pkg: shared widths, limits, register codes, controller states and the
// control struct passed from the controller to the match unit.
// No dependencies; compile first.
`default_nettype none

package rsc_pkg;

  localparam int VALUE_W   = 32;
  localparam int ITEM_W    = 10;
  localparam int TOTAL_W   = 19;
  localparam int CFG_IDX_W = 1;

  localparam logic [ITEM_W-1:0]  ITEM_MAX  = ITEM_W'(1023);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(524287);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clear;   // restart the hit count for a new element
    logic sample;  // read data is valid this cycle
    logic zero;    // this beat stands for entry zero, which always holds zero
  } match_ctl_t;

endpackage

`default_nettype wire

/* design/rsc_in_if.sv */
// rsc_in_if: element channel, valid/ready with a signed value and a first flag.
// Depends on rsc_pkg for the value width.
`default_nettype none

interface rsc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsc_pkg::VALUE_W-1:0] value;
  logic                               first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

`default_nettype wire

/* design/rsc_out_if.sv */
// rsc_out_if: result channel, valid/ready with per-element and running counts.
// Depends on rsc_pkg for the count widths.
`default_nettype none

interface rsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [rsc_pkg::ITEM_W-1:0]   item_hits;
  logic [rsc_pkg::TOTAL_W-1:0]  total_hits;
  logic                         store_full;

  modport source (output valid, output item_hits, output total_hits, output store_full,
                  input ready);
  modport sink   (input valid, input item_hits, input total_hits, input store_full,
                  output ready);
endinterface

`default_nettype wire

/* design/rsc_store.sv */
// rsc_store: prefix sum memory, one write port and one read port with
// registered read data. No dependencies.
`default_nettype none

module rsc_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 42
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/rsc_match.sv */
// rsc_match: window compare of one stored prefix per beat and hit counting.
// Depends on rsc_pkg (match_ctl_t).
`default_nettype none

module rsc_match #(
  parameter int SUM_W = 42,
  parameter int CNT_W = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rsc_pkg::match_ctl_t       ctl,
  input  wire logic signed [SUM_W-1:0]   prefix,
  input  wire logic signed [SUM_W:0]     win_lo,
  input  wire logic signed [SUM_W:0]     win_hi,
  output logic             [CNT_W-1:0]   count
);
  import rsc_pkg::*;

  logic signed [SUM_W:0] p_ext;
  logic                  hit;

  // entry zero is never written, it reads as zero here
  assign p_ext = ctl.zero ? '0 : (SUM_W+1)'(prefix);
  assign hit   = (p_ext >= win_lo) && (p_ext <= win_hi);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (ctl.sample && hit) begin
      count <= count + CNT_W'(1);
    end
  end

  // a clear never coincides with a sampled beat
  assert property (@(posedge clk) disable iff (rst) ctl.clear |-> !ctl.sample)
    else $error("match clear during sample");
  // an empty window never adds a hit
  assert property (@(posedge clk) disable iff (rst)
                   (!ctl.clear && win_lo > win_hi) |=> $stable(count))
    else $error("hit counted on empty window");
  // count moves by at most one per beat
  assert property (@(posedge clk) disable iff (rst)
                   !ctl.clear |=> (count == $past(count) ||
                                   count == $past(count) + CNT_W'(1)))
    else $error("hit count jumped");

endmodule

`default_nettype wire

/* design/range_sum_counter_top.sv */
// range_sum_counter_top: controller, running sum, bounds and result register.
// Depends on rsc_pkg, rsc_in_if, rsc_out_if, rsc_store and rsc_match.
//
//   channel  | dir | beat contents
//   elem     | in  | value (s32), first
//   result   | out | item_hits (10), total_hits (19), store_full
//   cfg      | in  | cfg_we, cfg_index, cfg_data (s32), write only
//
// an element passes through the accepting idle cycle, setup, one store read per
// stored prefix, a drain and a finish, where its result is registered. a dropped
// element (store full) goes from idle straight to finish. the scan is bound by
// the single read port. synchronous reset; no clearing pass, read data of entry
// zero is forced to zero. a result waiting on result.ready holds the block in
// finish; elem is taken again in the idle cycle after the result register frees.
`default_nettype none

module range_sum_counter_top #(
  parameter int MAX_PREFIXES = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  rsc_in_if.sink                                   elem,
  rsc_out_if.source                                result,
  input  wire logic                                cfg_we,
  input  wire logic [rsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic signed [rsc_pkg::VALUE_W-1:0]  cfg_data
);
  import rsc_pkg::*;

  localparam int AW     = (MAX_PREFIXES > 1) ? $clog2(MAX_PREFIXES) : 1;
  localparam int FILL_W = $clog2(MAX_PREFIXES + 1);
  localparam int CNT_W  = FILL_W;
  localparam int SUM_W  = VALUE_W + AW;
  localparam int HW     = (CNT_W > ITEM_W) ? CNT_W : ITEM_W;
  localparam int TW     = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PREFIXES);

  state_t state, state_next;

  logic signed [VALUE_W-1:0] lower_bound, upper_bound;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W:0]     win_lo, win_hi;
  logic [FILL_W-1:0]         fill;
  logic [TOTAL_W-1:0]        total;
  logic [AW-1:0]             idx;
  logic                      drop;
  logic                      rd_valid, rd_zero;

  logic                      out_valid;
  logic [ITEM_W-1:0]         out_item;
  logic [TOTAL_W-1:0]        out_total;
  logic                      out_full;

  logic                      accept, out_free, last_idx;
  logic                      rd_en, wr_en;
  logic [SUM_W-1:0]          rd_data;
  logic [CNT_W-1:0]          count;
  match_ctl_t                ctl;

  logic [HW-1:0]             cnt_ext;
  logic [ITEM_W-1:0]         item_sat;
  logic [TW-1:0]             tot_sum;
  logic [TOTAL_W-1:0]        total_next;

  assign accept   = elem.valid && elem.ready;
  assign out_free = !out_valid || result.ready;
  assign last_idx = (FILL_W'(idx) == fill - FILL_W'(1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
      upper_bound <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOWER: lower_bound <= cfg_data;
        REG_UPPER: upper_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    elem.ready = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    ctl.clear  = 1'b0;
    ctl.sample = rd_valid;
    ctl.zero   = rd_zero;
    case (state)
      S_IDLE: begin
        elem.ready = !rst;
        if (elem.valid) begin
          state_next = (!elem.first && fill >= FILL_MAX) ? S_FINISH : S_SETUP;
        end
      end
      S_SETUP: begin
        ctl.clear  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          wr_en      = !drop;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // saturation of the per-element and running counts
  assign cnt_ext    = HW'(count);
  assign item_sat   = (cnt_ext > HW'(ITEM_MAX)) ? ITEM_MAX : cnt_ext[ITEM_W-1:0];
  assign tot_sum    = TW'(total) + TW'(count);
  assign total_next = (tot_sum > TW'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= FILL_W'(1);
      total    <= '0;
      sum      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (accept) begin
        if (elem.first) begin
          fill  <= FILL_W'(1);
          total <= '0;
          sum   <= {{AW{elem.value[VALUE_W-1]}}, elem.value};
        end else if (fill < FILL_MAX) begin
          sum <= sum + {{AW{elem.value[VALUE_W-1]}}, elem.value};
        end
      end
      if (wr_en) begin
        fill  <= fill + FILL_W'(1);
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= (idx == '0);
    if (accept) begin
      drop <= !elem.first && fill >= FILL_MAX;
    end
    if (state == S_SETUP) begin
      // stored p qualifies when sum - upper <= p <= sum - lower
      win_lo <= (SUM_W+1)'(sum) - (SUM_W+1)'(upper_bound);
      win_hi <= (SUM_W+1)'(sum) - (SUM_W+1)'(lower_bound);
      idx    <= '0;
    end else if (rd_en) begin
      idx <= idx + AW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_item  <= drop ? '0 : item_sat;
      out_total <= drop ? total : total_next;
      out_full  <= drop;
    end
  end

  assign result.valid      = out_valid;
  assign result.item_hits  = out_item;
  assign result.total_hits = out_total;
  assign result.store_full = out_full;

  rsc_store #(
    .DEPTH (MAX_PREFIXES),
    .WIDTH (SUM_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data (sum),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  rsc_match #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_match (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .prefix (rd_data),
    .win_lo (win_lo),
    .win_hi (win_hi),
    .count  (count)
  );

  // the store is never written past its depth
  assert property (@(posedge clk) disable iff (rst) wr_en |-> fill < FILL_MAX)
    else $error("prefix store overrun");
  // the scan stays inside the filled part of the store
  assert property (@(posedge clk) disable iff (rst) state == S_SCAN |-> FILL_W'(idx) < fill)
    else $error("scan past fill count");
  // hits of one element never exceed the prefixes scanned
  assert property (@(posedge clk) disable iff (rst) state == S_FINISH && !drop |->
                   FILL_W'(count) <= fill)
    else $error("hit count above fill count");
  // an accepted element always leaves idle
  assert property (@(posedge clk) disable iff (rst) accept |=> state != S_IDLE)
    else $error("element accepted without work");

endmodule

`default_nettype wire
